// ===== hdl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque block.
// No dependencies; imported by every module of the block.
package bdq_pkg;

    localparam int WORD_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 7;
    localparam int FILL_W    = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_BACK   = 2'd2,
        MODE_POP_FRONT  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/bdq_ctrl.sv =====
// Sequencing controller for the bounded deque: accept, execute, load result.
// Depends on bdq_pkg for the command and status structs.
module bdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bdq_pkg::t_stat i_stat,
    output bdq_pkg::t_cmd  o_cmd
);
    import bdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept  = o_ready && i_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/bdq_dpath.sv =====
// Datapath for the bounded deque: ring buffer memory, pointers, count,
// capacity register and output register. Depends on bdq_pkg.
module bdq_dpath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bdq_pkg::t_cmd                      i_cmd,
    output bdq_pkg::t_stat                     o_stat,
    input  logic                               i_cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]          i_cfg_data,
    input  logic [bdq_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [bdq_pkg::WORD_W-1:0]  i_push_value,
    input  logic                               i_ready,
    output logic                               o_valid,
    output logic signed [bdq_pkg::WORD_W-1:0]  o_pop_value,
    output logic [bdq_pkg::STATUS_W-1:0]       o_status,
    output logic [bdq_pkg::FILL_W-1:0]         o_fill_count
);
    import bdq_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = AW + 1;
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic [WORD_W-1:0] r_mem [DEPTH];

    logic [CAP_W-1:0]  r_cap;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     r_front;
    logic [AW-1:0]     n_front;
    t_mode             r_mode;
    logic [WORD_W-1:0] r_push_value;
    logic [WORD_W-1:0] r_rd_data;
    t_status           r_status;
    t_status           n_status;
    logic              r_pop_ok;
    logic              n_pop_ok;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_pop;
    t_status           r_out_status;
    logic [FILL_W-1:0] r_out_fill;

    logic [CMPW-1:0]   eff_cap;
    logic              full;
    logic              empty;
    logic [SW-1:0]     back_sum;
    logic [SW-1:0]     last_sum;
    logic [AW-1:0]     back_addr;
    logic [AW-1:0]     last_addr;
    logic [AW-1:0]     front_dec;
    logic [AW-1:0]     front_inc;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    // Capacity saturates at the built depth.
    assign eff_cap = (CMPW'(r_cap) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(r_cap);
    assign full    = CMPW'(r_count) >= eff_cap;
    assign empty   = (r_count == '0);

    // Ring index arithmetic: sums stay below twice the depth.
    assign back_sum  = {1'b0, r_front} + SW'(r_count);
    assign last_sum  = back_sum - SW'(1);
    assign back_addr = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
    assign last_addr = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    always_comb begin
        n_count  = r_count;
        n_front  = r_front;
        n_status = ST_DONE;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = back_addr;
        rd_addr  = r_front;
        case (r_mode)
            MODE_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_PUSH_FRONT: begin
                wr_addr = front_dec;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_POP_BACK: begin
                rd_addr = last_addr;
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_front  = front_inc;
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_push_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_front     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_count <= n_count;
                r_front <= n_front;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode       <= t_mode'(i_mode);
            r_push_value <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
        if (i_cmd.load) begin
            r_out_pop    <= r_pop_ok ? r_rd_data : '0;
            r_out_status <= r_status;
            r_out_fill   <= FILL_W'(r_count);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_pop_value     = r_out_pop;
    assign o_status        = r_out_status;
    assign o_fill_count    = r_out_fill;

endmodule

// ===== hdl/bounded_array_deque.sv =====
// Bounded double-ended queue of signed 32-bit words held in a ring buffer.
// Items are taken one at a time: a new item is accepted only back in the idle state,
// after the accept, memory access and result load of the last, and only while the
// output register is free, as set by the controller sequence around the memory ports.
// Reset (synchronous, active low) empties the queue and sets capacity to 64;
// the entry memory is not cleared.
module bounded_array_deque #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [bdq_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [bdq_pkg::WORD_W-1:0]  i_push_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [bdq_pkg::WORD_W-1:0]  o_pop_value,
    output logic [bdq_pkg::STATUS_W-1:0]       o_status,
    output logic [bdq_pkg::FILL_W-1:0]         o_fill_count
);
    import bdq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_fill_count (o_fill_count)
    );

endmodule

// ===== hdl/bdq_checker.sv =====
// Port-level checks for the bounded deque, bound to the top level.
// Depends on bdq_pkg for widths and status codes.
module bdq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_we,
    input logic [bdq_pkg::CAP_W-1:0]          i_cfg_data,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic [bdq_pkg::MODE_W-1:0]         i_mode,
    input logic signed [bdq_pkg::WORD_W-1:0]  i_push_value,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [bdq_pkg::WORD_W-1:0]  o_pop_value,
    input logic [bdq_pkg::STATUS_W-1:0]       o_status,
    input logic [bdq_pkg::FILL_W-1:0]         o_fill_count
);
    import bdq_pkg::*;

    // Hold a result until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    // One item in flight: drop ready right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("item accepted while another is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_DONE || o_status == ST_FULL || o_status == ST_EMPTY))
        else $error("undefined status code");

    // Failed operations carry no popped word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DONE) |-> (o_pop_value == '0))
        else $error("nonzero pop value on a failed operation");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_fill_count == '0))
        else $error("empty pop reports a nonzero count");

endmodule

bind bounded_array_deque bdq_checker u_bdq_checker (.*);

// ===== bench/bounded_array_deque_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bounded deque: watches the item channels and the capacity port.
// It keeps its own deque model, predicts each result and compares it. Uses bdq_pkg.
module bounded_array_deque_checker
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CAP_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic signed [WORD_W-1:0] i_push_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [WORD_W-1:0] i_pop_value,
    input  logic [STATUS_W-1:0]      i_status,
    input  logic [FILL_W-1:0]        i_fill_count,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int PTR_W = $clog2(DEPTH);

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        t_status                  status;
        logic [FILL_W-1:0]        fill_count;
    } t_deque_result;

    logic signed [WORD_W-1:0] slots [DEPTH];
    logic [FILL_W-1:0]        held;
    logic [PTR_W-1:0]         head;
    logic [CAP_W-1:0]         capacity_reg;
    t_deque_result            expected_q [$];

    // Apply one operation to the model deque and return what the block must report.
    task automatic apply_op(input t_mode op, input logic signed [WORD_W-1:0] word,
                            output t_deque_result res);
        int limit;
        int slot;
        limit = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
        res.pop_value = '0;
        res.status    = ST_DONE;
        if (op == MODE_PUSH_BACK || op == MODE_PUSH_FRONT) begin
            if (int'(held) >= limit) begin
                res.status = ST_FULL;
            end else if (op == MODE_PUSH_BACK) begin
                slot        = (int'(head) + int'(held)) % DEPTH;
                slots[slot] = word;
                held        = held + 1'b1;
            end else begin
                head        = PTR_W'((int'(head) + DEPTH - 1) % DEPTH);
                slots[head] = word;
                held        = held + 1'b1;
            end
        end else if (held == '0) begin
            res.status = ST_EMPTY;
        end else if (op == MODE_POP_BACK) begin
            slot          = (int'(head) + int'(held) - 1) % DEPTH;
            res.pop_value = slots[slot];
            held          = held - 1'b1;
        end else begin
            res.pop_value = slots[head];
            head          = PTR_W'((int'(head) + 1) % DEPTH);
            held          = held - 1'b1;
        end
        res.fill_count = held;
    endtask

    always @(posedge i_clk) begin
        t_deque_result want;
        t_deque_result next_want;
        if (!i_rst_n) begin
            held         = '0;
            head         = '0;
            capacity_reg = CAP_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                capacity_reg = i_cfg_data;
            end
            // Compare before predicting so a result can never match its own item.
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: pop_value %0d status %0d fill %0d",
                           i_pop_value, i_status, i_fill_count);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (i_pop_value !== want.pop_value) begin
                        $error("pop_value mismatch: expected %0d, actual %0d",
                               want.pop_value, i_pop_value);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_fill_count !== want.fill_count) begin
                        $error("fill_count mismatch: expected %0d, actual %0d",
                               want.fill_count, i_fill_count);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_op(t_mode'(i_mode), i_push_value, next_want);
                expected_q.push_back(next_want);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== bench/bounded_array_deque_tb.sv =====
`timescale 1ns / 100ps
// Top of the bounded deque bench: clock, reset, capacity writes and item traffic.
// Needs bdq_pkg, bounded_array_deque and bounded_array_deque_checker.
module bounded_array_deque_tb;
    import bdq_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_PHASES       = 12;
    localparam int PHASE_ITEMS    = 148;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     cfg_we     = 1'b0;
    logic [CAP_W-1:0]         cfg_data   = CAP_RESET;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    t_mode                    mode       = MODE_PUSH_BACK;
    logic signed [WORD_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [WORD_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;
    logic [FILL_W-1:0]        fill_count;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int stall_cycles  = 0;
    int hold_requests = 0;
    bit gaps_on       = 1'b1;

    bounded_array_deque dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_mode       (mode),
        .i_push_value (push_value),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_pop_value  (pop_value),
        .o_status     (status),
        .o_fill_count (fill_count)
    );

    bounded_array_deque_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_mode       (mode),
        .i_push_value (push_value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_pop_value  (pop_value),
        .i_status     (status),
        .i_fill_count (fill_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one item, idling first at random, and return at the edge that takes it.
    task automatic send_op(input t_mode op, input logic [WORD_W-1:0] word);
        while (gaps_on && $urandom_range(0, 99) < 22) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        push_value <= word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request.
    initial begin
        int served;
        served = 0;
        forever begin
            @(posedge clk);
            if (hold_requests > served) begin
                served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= (!gaps_on || $urandom_range(0, 99) >= 22);
        end
    end

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            results_seen <= results_seen + 1;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [CAP_W-1:0] phase_cap [N_PHASES];
        int               push_bias;
        t_mode            op;
        logic [WORD_W-1:0] word;

        // Phases cycle push-heavy, pop-heavy, balanced.
        phase_cap[0]  = CAP_W'(64);
        phase_cap[1]  = CAP_W'(1);
        phase_cap[2]  = CAP_W'(2);
        phase_cap[3]  = CAP_W'(127);
        phase_cap[4]  = CAP_W'(0);
        phase_cap[5]  = CAP_W'(16);
        phase_cap[6]  = CAP_W'(65);
        phase_cap[7]  = CAP_W'(3);
        phase_cap[8]  = CAP_W'(33);
        phase_cap[9]  = CAP_W'($urandom_range(4, 127));
        phase_cap[10] = CAP_W'(64);
        phase_cap[11] = CAP_W'($urandom_range(4, 127));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops on an empty deque, then extremes pushed at both ends and popped from both ends.
        send_op(MODE_POP_BACK, 32'h0000_0000);
        send_op(MODE_POP_FRONT, 32'h1234_5678);
        send_op(MODE_PUSH_BACK, 32'h7FFF_FFFF);
        send_op(MODE_PUSH_FRONT, 32'h8000_0000);
        send_op(MODE_PUSH_BACK, 32'h0000_0000);
        send_op(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(MODE_PUSH_BACK, 32'h5555_5555);
        send_op(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
        send_op(MODE_POP_FRONT, 32'hFFFF_FFFF);
        send_op(MODE_POP_BACK, 32'h0000_0000);
        send_op(MODE_POP_BACK, 32'hFFFF_FFFF);
        send_op(MODE_POP_FRONT, 32'h0000_0000);

        // Capacity of one, lowered below the two entries still held.
        set_capacity(CAP_W'(1));
        send_op(MODE_PUSH_BACK, 32'h0BAD_F00D);
        send_op(MODE_PUSH_FRONT, 32'h0000_0001);
        send_op(MODE_POP_BACK, 32'h0000_0000);
        send_op(MODE_PUSH_BACK, 32'h0000_0002);
        send_op(MODE_POP_FRONT, 32'h0000_0000);
        send_op(MODE_PUSH_FRONT, 32'hDEAD_BEEF);
        send_op(MODE_PUSH_BACK, 32'h0000_0003);

        // Capacity zero: every push is refused.
        set_capacity(CAP_W'(0));
        send_op(MODE_PUSH_BACK, 32'h0000_0004);
        send_op(MODE_POP_FRONT, 32'h0000_0000);
        send_op(MODE_PUSH_FRONT, 32'h0000_0005);
        send_op(MODE_POP_BACK, 32'h0000_0000);

        for (int p = 0; p < N_PHASES; p++) begin
            set_capacity(phase_cap[p]);
            gaps_on   = (p != 5 && p != 6);
            push_bias = (p % 3 == 0) ? 75 : ((p % 3 == 1) ? 30 : 50);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 1 && k == 40) begin
                    hold_requests++;
                end
                if (p == 7 && k == 70) begin
                    wait_drained();
                end
                if ($urandom_range(0, 99) < push_bias) begin
                    op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
                end else begin
                    op = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
                end
                case ($urandom_range(0, 15))
                    0:       word = 32'h7FFF_FFFF;
                    1:       word = 32'h8000_0000;
                    2:       word = '0;
                    3:       word = '1;
                    default: word = $urandom();
                endcase
                send_op(op, word);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Ran %0d deque operations with %0d results checked over %0d capacity writes,",
                 items_sent, results_seen, cfg_writes);
        $display("covering capacities 0, 1, 64 and above 64, full and empty ends, and back-pressure.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bdq_pkg.sv
hdl/bdq_ctrl.sv
hdl/bdq_dpath.sv
hdl/bounded_array_deque.sv
hdl/bdq_checker.sv
bench/bounded_array_deque_checker.sv
bench/bounded_array_deque_tb.sv
